// File: rtl/tmdp_pkg.sv
// ----------------------------------------------------------------------------
// tmdp_pkg
// Shared types and field widths for the tile map delta present core.
// ----------------------------------------------------------------------------
package tmdp_pkg;

    localparam int FUNC_W = 2;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int TILE_W = 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE   = 2'd0,
        FN_PRESENT = 2'd1,
        FN_SWAP    = 2'd2,
        FN_CLEAR   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FLUSH,
        ST_CLEAR
    } t_state;

endpackage

// File: rtl/tmdp_ram.sv
// ----------------------------------------------------------------------------
// tmdp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tmdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tile_map_delta_present_core.sv
// ----------------------------------------------------------------------------
// tile_map_delta_present_core
// Double-buffered tile map with a shadow of the display map; present-row
// commands emit one beat per tile that differs from the shadow.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | in        | i_in_valid / o_in_stall | i_func i_row i_col i_tile
//   out     | out       | o_out_valid / i_out_stall| o_out_row o_out_col o_out_tile o_last
//   cfg     | in        | i_cfg_valid / o_cfg_ready| i_cfg_data (blank tile)
//
// Write and swap are done in ST_IDLE as they are accepted. Present row walks
// the row with one read state and one compare state per column on the single
// read port of each memory, then a flush state. Clear sweeps the back buffer.
// After reset a clearing pass zeroes all three memories with o_in_stall high.
// A stalled output only holds the walk when a second changed tile is found
// with the output register still full.
// ----------------------------------------------------------------------------
module tile_map_delta_present_core
    import tmdp_pkg::*;
#(
    parameter int ROWS = 32,
    parameter int COLS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [COL_W-1:0]  i_col,
    input  logic [TILE_W-1:0] i_tile,

    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ROW_W-1:0]  o_out_row,
    output logic [COL_W-1:0]  o_out_col,
    output logic [TILE_W-1:0] o_out_tile,
    output logic              o_last,

    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [TILE_W-1:0] i_cfg_data
);

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS - 1);

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_addr;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic                r_back_is_b;
    logic [TILE_W-1:0]   r_blank_tile;

    logic                r_held_valid;
    logic [COL_W-1:0]    r_held_col;
    logic [TILE_W-1:0]   r_held_tile;

    logic                r_out_valid;
    logic [ROW_W-1:0]    r_out_row;
    logic [COL_W-1:0]    r_out_col;
    logic [TILE_W-1:0]   r_out_tile;
    logic                r_out_last;

    t_func               w_func;
    logic                w_in_acc;
    logic                w_row_ok;
    logic                w_col_ok;
    logic [ADDR_W-1:0]   w_row_base;
    logic [ADDR_W-1:0]   w_wr_idx;
    logic                w_slot_ok;
    logic                w_diff;
    logic                w_col_end;
    logic                w_rd_en;
    logic                w_advance;
    logic                w_push;
    logic                w_push_last;
    logic                w_back_we;
    logic                w_init_we;
    logic                w_a_we, w_b_we, w_sh_we;
    logic [ADDR_W-1:0]   w_buf_waddr;
    logic [TILE_W-1:0]   w_buf_wdata;
    logic [TILE_W-1:0]   w_sh_wdata;
    logic [TILE_W-1:0]   w_a_rdata, w_b_rdata, w_sh_rdata, w_back_rdata;

    assign w_func     = t_func'(i_func);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_row_ok   = {1'b0, i_row} < 7'(ROWS);
    assign w_col_ok   = {1'b0, i_col} < 7'(COLS);
    assign w_row_base = ADDR_W'(i_row) * COLS_A;
    assign w_wr_idx   = w_row_base + ADDR_W'(i_col);
    assign w_slot_ok  = !r_out_valid || !i_out_stall;
    assign w_back_rdata = r_back_is_b ? w_b_rdata : w_a_rdata;
    assign w_diff     = w_back_rdata != w_sh_rdata;
    assign w_col_end  = r_col == LAST_COL;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_addr == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_in_acc && w_func == FN_PRESENT && w_row_ok) n_state = ST_READ;
                else if (w_in_acc && w_func == FN_CLEAR) n_state = ST_CLEAR;
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (w_advance) n_state = w_col_end ? ST_FLUSH : ST_READ;
            end
            ST_FLUSH: begin
                if (!r_held_valid || w_slot_ok) n_state = ST_IDLE;
            end
            ST_CLEAR: begin
                if (r_addr == LAST_ADDR) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall  = 1'b1;
        w_rd_en     = 1'b0;
        w_advance   = 1'b0;
        w_push      = 1'b0;
        w_push_last = 1'b0;
        w_back_we   = 1'b0;
        w_init_we   = 1'b0;
        w_sh_we     = 1'b0;
        w_buf_waddr = r_addr;
        w_buf_wdata = r_blank_tile;
        w_sh_wdata  = w_back_rdata;
        case (r_state)
            ST_INIT: begin
                w_init_we   = 1'b1;
                w_buf_wdata = '0;
                w_sh_wdata  = '0;
            end
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                w_buf_waddr = w_wr_idx;
                w_buf_wdata = i_tile;
                w_back_we   = w_in_acc && w_func == FN_WRITE && w_row_ok && w_col_ok;
            end
            ST_READ: begin
                w_rd_en = 1'b1;
            end
            ST_CMP: begin
                w_advance = !(w_diff && r_held_valid && !w_slot_ok);
                w_push    = w_diff && r_held_valid && w_slot_ok;
                w_sh_we   = w_advance && w_diff;
            end
            ST_FLUSH: begin
                w_push      = r_held_valid && w_slot_ok;
                w_push_last = 1'b1;
            end
            ST_CLEAR: begin
                w_back_we = 1'b1;
            end
            default: ;
        endcase
    end

    assign w_a_we = w_init_we || (w_back_we && !r_back_is_b);
    assign w_b_we = w_init_we || (w_back_we && r_back_is_b);

    tmdp_ram #(.WIDTH(TILE_W), .DEPTH(CELLS)) u_buf_a (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_buf_waddr),
        .i_wdata (w_buf_wdata),
        .i_re    (w_rd_en),
        .i_raddr (r_addr),
        .o_rdata (w_a_rdata)
    );

    tmdp_ram #(.WIDTH(TILE_W), .DEPTH(CELLS)) u_buf_b (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_buf_waddr),
        .i_wdata (w_buf_wdata),
        .i_re    (w_rd_en),
        .i_raddr (r_addr),
        .o_rdata (w_b_rdata)
    );

    tmdp_ram #(.WIDTH(TILE_W), .DEPTH(CELLS)) u_shadow (
        .i_clk   (i_clk),
        .i_we    (w_sh_we || w_init_we),
        .i_waddr (r_addr),
        .i_wdata (w_sh_wdata),
        .i_re    (w_rd_en),
        .i_raddr (r_addr),
        .o_rdata (w_sh_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_addr       <= '0;
            r_back_is_b  <= 1'b0;
            r_blank_tile <= '0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                r_blank_tile <= i_cfg_data;
            end

            case (r_state)
                ST_INIT, ST_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                end
                ST_IDLE: begin
                    if (w_in_acc) begin
                        case (w_func)
                            FN_PRESENT: begin
                                r_addr       <= w_row_base;
                                r_col        <= '0;
                                r_row        <= i_row;
                                r_held_valid <= 1'b0;
                            end
                            FN_SWAP:  r_back_is_b <= !r_back_is_b;
                            FN_CLEAR: r_addr <= '0;
                            default: ;
                        endcase
                    end
                end
                ST_CMP: begin
                    if (w_advance) begin
                        r_addr <= r_addr + 1'b1;
                        r_col  <= r_col + 1'b1;
                        if (w_diff) begin
                            r_held_valid <= 1'b1;
                            r_held_col   <= r_col;
                            r_held_tile  <= w_back_rdata;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (w_push) r_held_valid <= 1'b0;
                end
                default: ;
            endcase

            if (w_push) begin
                r_out_valid <= 1'b1;
                r_out_row   <= r_row;
                r_out_col   <= r_held_col;
                r_out_tile  <= r_held_tile;
                r_out_last  <= w_push_last;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_tile  = r_out_tile;
    assign o_last      = r_out_last;

    a_present_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_func == FN_PRESENT && w_row_ok) |=> (r_state == ST_READ))
        else $error("present row did not start a walk");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_push_last) |=> (!r_held_valid && r_state == ST_IDLE))
        else $error("held tile left after last beat");

    a_no_write_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_INIT) |-> !(w_sh_we && (w_a_we || w_b_we)))
        else $error("shadow and buffer written together");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_addr <= LAST_ADDR))
        else $error("read address beyond the map");

    a_push_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP && w_diff && r_held_valid && !w_slot_ok) |=>
        (r_state == ST_CMP && $stable(r_col)))
        else $error("walk advanced over a full output register");

endmodule
